// ----- rtl/rc4_pkg.sv -----
// Package with shared constants, operation codes and control structs of the RC4 engine.
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

  localparam int BYTE_W      = 8;
  localparam int SBOX_DEPTH  = 256;
  localparam int KEY_MAX_DEF = 256;

  typedef enum logic {
    OP_KEY  = 1'b0,
    OP_DATA = 1'b1
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic key_wr;      // store an accepted key byte
    logic sched_start; // last key byte accepted: prepare the key schedule
    logic data_take;   // latch an accepted data byte
    logic fill_step;   // write one identity entry into the permutation
    logic ks_rdi;      // keystream: advance i, read S[i]
    logic ks_rdj;      // keystream: advance j, read S[j]
    logic ks_wri;      // keystream: write S[i]
    logic ks_wrj;      // keystream: write S[j]
    logic ks_rdk;      // keystream: read S[S[i] + S[j]]
    logic ks_out;      // keystream: load the output register
    logic mx_rdn;      // schedule: read S[n] and the key byte
    logic mx_rdj;      // schedule: advance j, read S[j]
    logic mx_wrn;      // schedule: write S[n]
    logic mx_wrj;      // schedule: write S[j], step n and the key index
    logic sched_done;  // schedule finished: clear indices and key count
  } rc4_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_last;   // sweep counter is at its last entry
    logic out_free; // output register can take a new result this cycle
  } rc4_sts_t;

endpackage

`default_nettype wire

// ----- rtl/rc4_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rc4_datapath.sv -----
// Datapath of the RC4 engine: permutation and key memories, indices, output register.
`timescale 1ns / 1ps
`default_nettype none

module rc4_datapath import rc4_pkg::*; #(
  parameter int KEY_MAX = KEY_MAX_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rc4_cmd_t          cmd,
  output rc4_sts_t               sts,
  input  wire logic [BYTE_W-1:0] value_byte,
  input  wire logic              last_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [BYTE_W-1:0] result_byte,
  output logic                   end_of_message
);

  localparam int KEY_AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int KCW    = $clog2(KEY_MAX + 1);
  localparam int SAW    = $clog2(SBOX_DEPTH);

  logic [SAW-1:0]    n;
  logic [SAW-1:0]    idx_i;
  logic [SAW-1:0]    idx_j;
  logic [BYTE_W-1:0] a_reg;
  logic [BYTE_W-1:0] b_reg;
  logic [BYTE_W-1:0] val_reg;
  logic              last_reg;
  logic [KCW-1:0]    key_count;
  logic [KEY_AW-1:0] key_k;

  logic              s_we;
  logic [SAW-1:0]    s_waddr;
  logic [BYTE_W-1:0] s_wdata;
  logic              s_re;
  logic [SAW-1:0]    s_raddr;
  logic [BYTE_W-1:0] s_rdata;

  logic              k_we;
  logic              k_re;
  logic [BYTE_W-1:0] k_rdata;

  logic [SAW-1:0]    i_inc;
  logic [SAW-1:0]    j_ks;
  logic [SAW-1:0]    j_mx;
  logic [KCW-1:0]    key_len;
  logic [KCW-1:0]    key_k_inc;
  logic              key_wrap;

  assign i_inc     = idx_i + SAW'(1);
  assign j_ks      = idx_j + s_rdata;
  assign j_mx      = idx_j + s_rdata + k_rdata;
  // A count of zero cannot occur during a schedule; it stands for a full key.
  assign key_len   = (key_count == '0) ? KCW'(KEY_MAX) : key_count;
  assign key_k_inc = KCW'(key_k) + KCW'(1);
  assign key_wrap  = (key_k_inc >= key_len);

  assign k_we = cmd.key_wr && (key_count < KCW'(KEY_MAX));
  assign k_re = cmd.mx_rdn;

  always_comb begin
    s_we    = 1'b0;
    s_waddr = n;
    s_wdata = s_rdata;
    s_re    = 1'b0;
    s_raddr = n;
    if (cmd.fill_step) begin
      s_we    = 1'b1;
      s_waddr = n;
      s_wdata = n;
    end
    if (cmd.ks_wri) begin
      s_we    = 1'b1;
      s_waddr = idx_i;
    end
    if (cmd.mx_wrn) begin
      s_we    = 1'b1;
      s_waddr = n;
    end
    if (cmd.ks_wrj || cmd.mx_wrj) begin
      s_we    = 1'b1;
      s_waddr = idx_j;
      s_wdata = a_reg;
    end
    if (cmd.ks_rdi) begin
      s_re    = 1'b1;
      s_raddr = i_inc;
    end
    if (cmd.ks_rdj) begin
      s_re    = 1'b1;
      s_raddr = j_ks;
    end
    if (cmd.ks_rdk) begin
      s_re    = 1'b1;
      s_raddr = a_reg + b_reg;
    end
    if (cmd.mx_rdn) begin
      s_re    = 1'b1;
      s_raddr = n;
    end
    if (cmd.mx_rdj) begin
      s_re    = 1'b1;
      s_raddr = j_mx;
    end
  end

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SBOX_DEPTH)
  ) u_sbox (
    .clk     (clk),
    .wr_en   (s_we),
    .wr_addr (s_waddr),
    .wr_data (s_wdata),
    .rd_en   (s_re),
    .rd_addr (s_raddr),
    .rd_data (s_rdata)
  );

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (KEY_MAX)
  ) u_key (
    .clk     (clk),
    .wr_en   (k_we),
    .wr_addr (key_count[KEY_AW-1:0]),
    .wr_data (value_byte),
    .rd_en   (k_re),
    .rd_addr (key_k),
    .rd_data (k_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      n         <= '0;
      idx_i     <= '0;
      idx_j     <= '0;
      key_count <= '0;
      key_k     <= '0;
      out_valid <= 1'b0;
    end else begin
      // The sweep counter wraps to zero at the end of every full sweep.
      if (cmd.fill_step || cmd.mx_wrj) begin
        n <= n + SAW'(1);
      end
      if (cmd.ks_rdi) begin
        idx_i <= i_inc;
      end
      if (cmd.ks_rdj) begin
        idx_j <= j_ks;
      end
      if (cmd.mx_rdj) begin
        idx_j <= j_mx;
      end
      if (cmd.sched_start) begin
        idx_j <= '0;
        key_k <= '0;
      end
      if (cmd.mx_wrj) begin
        key_k <= key_wrap ? '0 : key_k_inc[KEY_AW-1:0];
      end
      if (k_we) begin
        key_count <= key_count + KCW'(1);
      end
      if (cmd.sched_done) begin
        idx_i     <= '0;
        idx_j     <= '0;
        key_count <= '0;
      end
      if (cmd.ks_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ks_rdj || cmd.mx_rdj) begin
      a_reg <= s_rdata;
    end
    if (cmd.ks_wri) begin
      b_reg <= s_rdata;
    end
    if (cmd.data_take) begin
      val_reg  <= value_byte;
      last_reg <= last_byte;
    end
    if (cmd.ks_out) begin
      result_byte    <= val_reg ^ s_rdata;
      end_of_message <= last_reg;
    end
  end

  assign sts.n_last   = (n == SAW'(SBOX_DEPTH - 1));
  assign sts.out_free = !out_valid || out_ready;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    key_count <= KCW'(KEY_MAX))
    else $error("key count exceeds the key store depth");

  a_key_index: assert property (@(posedge clk) disable iff (rst)
    cmd.mx_rdn |-> (KCW'(key_k) < key_count))
    else $error("key schedule reads beyond the stored key");

  a_sched_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.sched_done |=> (idx_i == '0) && (idx_j == '0) && (key_count == '0))
    else $error("indices or key count not cleared after the schedule");
`endif

endmodule

`default_nettype wire

// ----- rtl/rc4_ctrl.sv -----
// Controller state machine of the RC4 engine: request handshake and step sequencing.
`timescale 1ns / 1ps
`default_nettype none

module rc4_ctrl import rc4_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     op,
  input  wire logic     last_byte,
  input  wire rc4_sts_t sts,
  output rc4_cmd_t      cmd
);

  typedef enum logic [11:0] {
    ST_FILL   = 12'b0000_0000_0001,
    ST_IDLE   = 12'b0000_0000_0010,
    ST_KS_RDI = 12'b0000_0000_0100,
    ST_KS_RDJ = 12'b0000_0000_1000,
    ST_KS_WRI = 12'b0000_0001_0000,
    ST_KS_WRJ = 12'b0000_0010_0000,
    ST_KS_RDK = 12'b0000_0100_0000,
    ST_KS_OUT = 12'b0000_1000_0000,
    ST_MX_RDN = 12'b0001_0000_0000,
    ST_MX_RDJ = 12'b0010_0000_0000,
    ST_MX_WRN = 12'b0100_0000_0000,
    ST_MX_WRJ = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   mix_pending;
  logic   mix_pending_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next       = state;
    mix_pending_next = mix_pending;
    cmd              = '0;
    case (state)
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.n_last) begin
          state_next       = mix_pending ? ST_MX_RDN : ST_IDLE;
          mix_pending_next = 1'b0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (op == OP_DATA) begin
            cmd.data_take = 1'b1;
            state_next    = ST_KS_RDI;
          end else begin
            cmd.key_wr = 1'b1;
            if (last_byte) begin
              // The schedule first rebuilds the identity permutation.
              cmd.sched_start  = 1'b1;
              mix_pending_next = 1'b1;
              state_next       = ST_FILL;
            end
          end
        end
      end
      ST_KS_RDI: begin
        cmd.ks_rdi = 1'b1;
        state_next = ST_KS_RDJ;
      end
      ST_KS_RDJ: begin
        cmd.ks_rdj = 1'b1;
        state_next = ST_KS_WRI;
      end
      ST_KS_WRI: begin
        cmd.ks_wri = 1'b1;
        state_next = ST_KS_WRJ;
      end
      ST_KS_WRJ: begin
        cmd.ks_wrj = 1'b1;
        state_next = ST_KS_RDK;
      end
      ST_KS_RDK: begin
        cmd.ks_rdk = 1'b1;
        state_next = ST_KS_OUT;
      end
      ST_KS_OUT: begin
        if (sts.out_free) begin
          cmd.ks_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_MX_RDN: begin
        cmd.mx_rdn = 1'b1;
        state_next = ST_MX_RDJ;
      end
      ST_MX_RDJ: begin
        cmd.mx_rdj = 1'b1;
        state_next = ST_MX_WRN;
      end
      ST_MX_WRN: begin
        cmd.mx_wrn = 1'b1;
        state_next = ST_MX_WRJ;
      end
      ST_MX_WRJ: begin
        cmd.mx_wrj = 1'b1;
        if (sts.n_last) begin
          cmd.sched_done = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          state_next = ST_MX_RDN;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_FILL;
      mix_pending <= 1'b0;
    end else begin
      state       <= state_next;
      mix_pending <= mix_pending_next;
    end
  end

`ifndef ASSERT_OFF
  a_fill_to_mix: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) && sts.n_last && mix_pending |=> (state == ST_MX_RDN))
    else $error("identity fill of a key schedule did not continue into mixing");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.ks_out |-> sts.out_free)
    else $error("result loaded while the output register still holds one");

  a_pending_only_fill: assert property (@(posedge clk) disable iff (rst)
    mix_pending |-> (state == ST_FILL))
    else $error("pending key schedule outside the identity fill");
`endif

endmodule

`default_nettype wire

// ----- rtl/rc4_stream_cipher.sv -----
// RC4 stream cipher engine: usage notes
//
// One input channel (in_valid/in_ready) carries requests with op, value_byte
// and last_byte. op OP_KEY stores a key byte; a key byte with last_byte set
// starts the key schedule. op OP_DATA returns value_byte XOR the next keystream
// byte on the output channel (out_valid/out_ready) with end_of_message copied
// from last_byte. Key requests give no result.
// A data request steps through KS_RDI to KS_OUT; the next request is accepted
// in the cycle after the result is loaded, so no new request is taken while a
// data byte is in progress. Throughput is set by the single-write, single-read
// permutation RAM: three dependent reads and two writes per keystream byte.
// The key schedule follows the last key byte: an identity fill of 256 entries,
// then 256 mixing steps that each read S[n] and the key byte, read S[j], and
// write S[n] and S[j]. After reset the permutation is filled with identity,
// with in_ready low. When the receiver stalls, the result waits in the output
// register; one further data request is accepted and computed, and then holds
// until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module rc4_stream_cipher import rc4_pkg::*; #(
  parameter int KEY_MAX = KEY_MAX_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              op,
  input  wire logic [BYTE_W-1:0] value_byte,
  input  wire logic              last_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [BYTE_W-1:0] result_byte,
  output logic                   end_of_message
);

  rc4_cmd_t cmd;
  rc4_sts_t sts;

  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .last_byte (last_byte),
    .sts       (sts),
    .cmd       (cmd)
  );

  rc4_datapath #(
    .KEY_MAX (KEY_MAX)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .value_byte     (value_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_byte    (result_byte),
    .end_of_message (end_of_message)
  );

endmodule

`default_nettype wire
